// File: rtl/qslerp_pkg.sv
// shared constants for the quaternion slerp pipeline
package qslerp_pkg;
    localparam int ANG_BITS = 30;
    localparam int ANG_W    = 31;
    localparam int TERM_W   = 34;
    localparam int SUM_W    = 36;
    localparam int NEAR_W   = 15;
    localparam int SERIES_TERMS = 8;
    localparam logic [TERM_W-1:0] ANG_ONE   = TERM_W'(1) << ANG_BITS;
    localparam logic [ANG_W-1:0]  HALF_PI_Q = 31'd1686629713;
    localparam logic [NEAR_W-1:0] NEAR_RESET = 15'd16383;
endpackage

// File: rtl/qslerp_term_cell.sv
// one taylor term cell: two registered multiplies, constant divide, accumulate
module qslerp_term_cell #(
    parameter int Div = 2,
    parameter bit Neg = 1'b1,
    parameter int PW  = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [qslerp_pkg::ANG_W-1:0]          i_x,
    input  logic [qslerp_pkg::TERM_W-1:0]         i_term,
    input  logic signed [qslerp_pkg::SUM_W-1:0]   i_sum,
    input  logic [PW-1:0]                         i_pay,
    output logic                                  o_vld,
    output logic [qslerp_pkg::ANG_W-1:0]          o_x,
    output logic [qslerp_pkg::TERM_W-1:0]         o_term,
    output logic signed [qslerp_pkg::SUM_W-1:0]   o_sum,
    output logic [PW-1:0]                         o_pay
);
    import qslerp_pkg::*;
    localparam int PRW = TERM_W + ANG_W;

    logic [PRW-1:0]           w_pa, w_pb;
    logic [TERM_W-1:0]        w_tb, w_q;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     r_vld_a, r_vld_b;
    logic [ANG_W-1:0]         r_x_a, r_x_b;
    logic [TERM_W-1:0]        r_p_a, r_t_b;
    logic signed [SUM_W-1:0]  r_sum_a, r_sum_b;
    logic [PW-1:0]            r_pay_a, r_pay_b;

    always_comb begin
        w_pa = PRW'(i_term) * PRW'(i_x);
        w_pb = PRW'(r_p_a) * PRW'(r_x_a);
        w_tb = w_pb[ANG_BITS +: TERM_W];
        w_q  = w_tb / TERM_W'(Div);
        if (Neg) begin
            n_sum = r_sum_a - $signed({{(SUM_W-TERM_W){1'b0}}, w_q});
        end else begin
            n_sum = r_sum_a + $signed({{(SUM_W-TERM_W){1'b0}}, w_q});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x_a   <= i_x;
            r_p_a   <= w_pa[ANG_BITS +: TERM_W];
            r_sum_a <= i_sum;
            r_pay_a <= i_pay;
            r_x_b   <= r_x_a;
            r_t_b   <= w_q;
            r_sum_b <= n_sum;
            r_pay_b <= r_pay_a;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_x    = r_x_b;
    assign o_term = r_t_b;
    assign o_sum  = r_sum_b;
    assign o_pay  = r_pay_b;
endmodule

// File: rtl/qslerp_series.sv
// sin or cos series as a row of term cells
module qslerp_series #(
    parameter bit Odd = 1'b0,
    parameter int PW  = 1
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [qslerp_pkg::ANG_W-1:0]          i_x,
    input  logic [PW-1:0]                         i_pay,
    output logic                                  o_vld,
    output logic [qslerp_pkg::ANG_W-1:0]          o_x,
    output logic signed [qslerp_pkg::SUM_W-1:0]   o_sum,
    output logic [PW-1:0]                         o_pay
);
    import qslerp_pkg::*;
    localparam int NC = SERIES_TERMS - 1;

    logic                    w_vld  [0:NC];
    logic [ANG_W-1:0]        w_x    [0:NC];
    logic [TERM_W-1:0]       w_term [0:NC];
    logic signed [SUM_W-1:0] w_sum  [0:NC];
    logic [PW-1:0]           w_pay  [0:NC];

    assign w_vld[0]  = i_vld;
    assign w_x[0]    = i_x;
    assign w_term[0] = Odd ? TERM_W'(i_x) : ANG_ONE;
    assign w_sum[0]  = $signed({{(SUM_W-TERM_W){1'b0}}, w_term[0]});
    assign w_pay[0]  = i_pay;

    for (genvar i = 1; i <= NC; i++) begin : g_cell
        localparam int K = (Odd ? 1 : 0) + 2 * (i - 1);
        qslerp_term_cell #(.Div((K + 1) * (K + 2)), .Neg((i % 2) == 1), .PW(PW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_vld(w_vld[i-1]), .i_x(w_x[i-1]), .i_term(w_term[i-1]),
            .i_sum(w_sum[i-1]), .i_pay(w_pay[i-1]),
            .o_vld(w_vld[i]), .o_x(w_x[i]), .o_term(w_term[i]),
            .o_sum(w_sum[i]), .o_pay(w_pay[i])
        );
    end

    assign o_vld = w_vld[NC];
    assign o_x   = w_x[NC];
    assign o_sum = w_sum[NC];
    assign o_pay = w_pay[NC];
endmodule

// File: rtl/qslerp_acos_cell.sv
// one bit of the arc cosine search: cos of the trial angle, then keep or drop the bit
module qslerp_acos_cell #(
    parameter int Bit = 30,
    parameter int PW  = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [qslerp_pkg::ANG_W-1:0]  i_th,
    input  logic [qslerp_pkg::ANG_W-1:0]  i_d,
    input  logic [PW-1:0]                 i_pay,
    output logic                          o_vld,
    output logic [qslerp_pkg::ANG_W-1:0]  o_th,
    output logic [qslerp_pkg::ANG_W-1:0]  o_d,
    output logic [PW-1:0]                 o_pay
);
    import qslerp_pkg::*;
    localparam int SPW = 2 * ANG_W + PW;

    logic [ANG_W-1:0]        w_cand, w_cand_o, w_th, w_d;
    logic [SPW-1:0]          w_pay_o;
    logic signed [SUM_W-1:0] w_cos;
    logic                    w_vld, w_take;
    logic                    r_vld;
    logic [ANG_W-1:0]        r_th, r_d;
    logic [PW-1:0]           r_pay;

    assign w_cand = i_th | (ANG_W'(1) << Bit);

    qslerp_series #(.Odd(1'b0), .PW(SPW)) u_cos (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
        .i_vld(i_vld), .i_x(w_cand), .i_pay({i_th, i_d, i_pay}),
        .o_vld(w_vld), .o_x(w_cand_o), .o_sum(w_cos), .o_pay(w_pay_o)
    );

    assign w_th   = w_pay_o[PW+ANG_W +: ANG_W];
    assign w_d    = w_pay_o[PW +: ANG_W];
    assign w_take = (w_cand_o <= HALF_PI_Q) &&
                    (w_cos >= $signed({{(SUM_W-ANG_W){1'b0}}, w_d}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_th  <= w_take ? w_cand_o : w_th;
            r_d   <= w_d;
            r_pay <= w_pay_o[PW-1:0];
        end
    end

    assign o_vld = r_vld;
    assign o_th  = r_th;
    assign o_d   = r_d;
    assign o_pay = r_pay;
endmodule

// File: rtl/qslerp_divider.sv
// restoring divider, one quotient bit per cell, saturation flag from the input register
module qslerp_divider #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QB = 15,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_n,
    input  logic [DW-1:0] i_d,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [QB-1:0] o_q,
    output logic          o_sat,
    output logic [PW-1:0] o_pay
);
    localparam int XW = NW + DW + QB;

    logic          r_vld [0:QB];
    logic [NW-1:0] r_rem [0:QB];
    logic [DW-1:0] r_d   [0:QB];
    logic [QB-1:0] r_q   [0:QB];
    logic          r_sat [0:QB];
    logic [PW-1:0] r_pay [0:QB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_n;
            r_d[0]   <= i_d;
            r_q[0]   <= '0;
            r_sat[0] <= XW'(i_n) >= (XW'(i_d) << QB);
            r_pay[0] <= i_pay;
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_cell
        localparam int K = QB - 1 - j;
        logic [XW-1:0] w_cmp;
        logic          w_ge;
        assign w_cmp = XW'(r_d[j]) << K;
        assign w_ge  = XW'(r_rem[j]) >= w_cmp;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? r_rem[j] - w_cmp[NW-1:0] : r_rem[j];
                r_q[j+1]   <= w_ge ? (r_q[j] | (QB'(1) << K)) : r_q[j];
                r_d[j+1]   <= r_d[j];
                r_sat[j+1] <= r_sat[j];
                r_pay[j+1] <= r_pay[j];
            end
        end
    end

    assign o_vld = r_vld[QB];
    assign o_q   = r_q[QB];
    assign o_sat = r_sat[QB];
    assign o_pay = r_pay[QB];
endmodule

// File: rtl/qslerp_isqrt.sv
// integer square root, one result bit per cell
module qslerp_isqrt #(
    parameter int HW = 32,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [2*HW-1:0] i_v,
    input  logic [PW-1:0]   i_pay,
    output logic            o_vld,
    output logic [HW-1:0]   o_root,
    output logic [PW-1:0]   o_pay
);
    localparam int VW = 2 * HW;

    logic          w_vld [0:HW];
    logic [VW-1:0] w_v   [0:HW];
    logic [VW-1:0] w_res [0:HW];
    logic [PW-1:0] w_pay [0:HW];

    assign w_vld[0] = i_vld;
    assign w_v[0]   = i_v;
    assign w_res[0] = '0;
    assign w_pay[0] = i_pay;

    for (genvar j = 0; j < HW; j++) begin : g_cell
        localparam int SH = 2 * (HW - 1 - j);
        logic [VW:0]   w_trial;
        logic          w_ge;
        logic          r_vld;
        logic [VW-1:0] r_v, r_res;
        logic [PW-1:0] r_pay;

        assign w_trial = (VW+1)'(w_res[j]) + ((VW+1)'(1) << SH);
        assign w_ge    = (VW+1)'(w_v[j]) >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= w_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_v   <= w_ge ? w_v[j] - w_trial[VW-1:0] : w_v[j];
                r_res <= w_ge ? (w_res[j] >> 1) + (VW'(1) << SH) : (w_res[j] >> 1);
                r_pay <= w_pay[j];
            end
        end

        assign w_vld[j+1] = r_vld;
        assign w_v[j+1]   = r_v;
        assign w_res[j+1] = r_res;
        assign w_pay[j+1] = r_pay;
    end

    assign o_vld  = w_vld[HW];
    assign o_root = w_res[HW][HW-1:0];
    assign o_pay  = w_pay[HW];
endmodule

// File: rtl/quaternion_slerp.sv
// Normalized spherical linear interpolation of two quaternions, one request per cycle.
// Every request runs the whole pipeline: dot product, a 31-cell arc cosine search in
// which each cell runs an 8-term cosine series, three sine series in parallel, weight
// dividers, mixing, a 32-cell square root and four normalizing dividers. A new
// request is taken every cycle while the output register is empty or being drained;
// a stalled output holds the whole row.
// near_threshold is written through the cfg channel, which is always ready.
module quaternion_slerp #(
    parameter int FRAC_BITS       = 14,
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [qslerp_pkg::NEAR_W-1:0]          i_cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
    input  logic [((9*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // r_x, r_y, r_z, r_w
    output logic [((4*COMPONENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // degenerate
    output logic                                   m_axis_tuser
);
    import qslerp_pkg::*;

    localparam int CW  = COMPONENT_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int OW  = ((4*CW+7)/8)*8;
    localparam int WW  = FB + 2;
    localparam int DDW = 2*CW - FB + 3;
    localparam int PA  = 8*CW + (FB+1) + 2*WW + 2;
    localparam int AB  = 2 + 2*WW + FB + 1;
    localparam int X3W = ANG_W + FB + 1;
    localparam int SDW = 32;
    localparam int NW1 = SUM_W + FB;
    localparam int QB  = FB + 1;
    localparam int PWD = WW + CW;
    localparam int MW  = PWD;
    localparam int NW2 = MW + FB + 1;
    localparam int IPW = 4*MW + 4;
    localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

    logic w_en;
    logic [NEAR_W-1:0] r_thr;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= NEAR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // stage 1: component products
    logic                     r1_vld;
    logic signed [CW-1:0]     r1_a [0:3];
    logic signed [CW-1:0]     r1_b [0:3];
    logic signed [CW-1:0]     r1_t;
    logic signed [2*CW-1:0]   r1_p [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r1_a[i] <= $signed(s_axis_tdata[i*CW +: CW]);
                r1_b[i] <= $signed(s_axis_tdata[(4+i)*CW +: CW]);
                r1_p[i] <= $signed(s_axis_tdata[i*CW +: CW]) *
                           $signed(s_axis_tdata[(4+i)*CW +: CW]);
            end
            r1_t <= $signed(s_axis_tdata[8*CW +: CW]);
        end
    end

    // stage 2: dot, short path, clamps and path choice
    logic signed [DDW-1:0] w_d;
    logic [DDW-1:0]        w_dabs;
    logic [FB:0]           w_dmin, w_tf;
    logic                  w_flip, w_trig;
    logic signed [WW-1:0]  w_lin1, w_lin2;
    logic [8*CW-1:0]       w_ab;
    logic                  r2_vld;
    logic [ANG_W-1:0]      r2_d30;
    logic [PA-1:0]         r2_pay;

    always_comb begin
        w_d = '0;
        for (int i = 0; i < 4; i++) begin
            w_d = w_d + DDW'(r1_p[i] >>> FB);
            w_ab[i*CW +: CW]     = r1_a[i];
            w_ab[(4+i)*CW +: CW] = r1_b[i];
        end
        w_dabs = w_d[DDW-1] ? DDW'(-w_d) : DDW'(w_d);
        w_dmin = (w_dabs > DDW'(ONE)) ? ONE : w_dabs[FB:0];
        w_tf   = r1_t[FB:0];
        if (r1_t[CW-1]) begin
            w_lin2 = WW'(ONE);
            w_lin1 = '0;
            w_flip = 1'b0;
            w_trig = 1'b0;
        end else if (r1_t > $signed(CW'(ONE))) begin
            w_lin2 = '0;
            w_lin1 = WW'(ONE);
            w_flip = 1'b0;
            w_trig = 1'b0;
        end else begin
            w_lin2 = WW'(ONE) - WW'(w_tf);
            w_lin1 = WW'(w_tf);
            w_flip = w_d[DDW-1];
            w_trig = w_dabs <= DDW'(r_thr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d30 <= ANG_W'(w_dmin) << (ANG_BITS - FB);
            r2_pay <= {w_ab, w_tf, w_lin1, w_lin2, w_flip, w_trig};
        end
    end

    // arc cosine row
    logic             w_ac_vld [0:ANG_BITS+1];
    logic [ANG_W-1:0] w_ac_th  [0:ANG_BITS+1];
    logic [ANG_W-1:0] w_ac_d   [0:ANG_BITS+1];
    logic [PA-1:0]    w_ac_pay [0:ANG_BITS+1];

    assign w_ac_vld[0] = r2_vld;
    assign w_ac_th[0]  = '0;
    assign w_ac_d[0]   = r2_d30;
    assign w_ac_pay[0] = r2_pay;

    for (genvar j = 0; j <= ANG_BITS; j++) begin : g_acos
        qslerp_acos_cell #(.Bit(ANG_BITS - j), .PW(PA)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_ac_vld[j]), .i_th(w_ac_th[j]), .i_d(w_ac_d[j]),
            .i_pay(w_ac_pay[j]),
            .o_vld(w_ac_vld[j+1]), .o_th(w_ac_th[j+1]), .o_d(w_ac_d[j+1]),
            .o_pay(w_ac_pay[j+1])
        );
    end

    // stage 3: scaled angles
    logic [X3W-1:0] w_xa, w_xb;
    logic [FB:0]    w_t3;
    logic           r3_vld;
    logic [ANG_W-1:0] r3_th, r3_xa, r3_xb;
    logic [PA-1:0]  r3_pay;

    assign w_t3 = w_ac_pay[ANG_BITS+1][2+2*WW +: FB+1];
    assign w_xa = X3W'(w_t3) * X3W'(w_ac_th[ANG_BITS+1]);
    assign w_xb = X3W'(ONE - w_t3) * X3W'(w_ac_th[ANG_BITS+1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= w_ac_vld[ANG_BITS+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_th  <= w_ac_th[ANG_BITS+1];
            r3_xa  <= w_xa[FB +: ANG_W];
            r3_xb  <= w_xb[FB +: ANG_W];
            r3_pay <= w_ac_pay[ANG_BITS+1];
        end
    end

    // sines of theta, t*theta and (1-t)*theta
    logic                    w_s_vld, w_s1_vld, w_s2_vld;
    logic [ANG_W-1:0]        w_s_x, w_s1_x, w_s2_x;
    logic signed [SUM_W-1:0] w_s, w_s1, w_s2;
    logic [PA-1:0]           w_s_pay;
    logic                    w_s1_pay, w_s2_pay;

    qslerp_series #(.Odd(1'b1), .PW(PA)) u_sin_th (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(r3_vld), .i_x(r3_th), .i_pay(r3_pay),
        .o_vld(w_s_vld), .o_x(w_s_x), .o_sum(w_s), .o_pay(w_s_pay)
    );
    qslerp_series #(.Odd(1'b1), .PW(1)) u_sin_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(r3_vld), .i_x(r3_xa), .i_pay(1'b0),
        .o_vld(w_s1_vld), .o_x(w_s1_x), .o_sum(w_s1), .o_pay(w_s1_pay)
    );
    qslerp_series #(.Odd(1'b1), .PW(1)) u_sin_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(r3_vld), .i_x(r3_xb), .i_pay(1'b0),
        .o_vld(w_s2_vld), .o_x(w_s2_x), .o_sum(w_s2), .o_pay(w_s2_pay)
    );

    // stage 4: rounded dividends for the weights
    logic           r4_vld, r4_spos;
    logic [NW1-1:0] r4_n1, r4_n2;
    logic [SDW-1:0] r4_s;
    logic [PA-1:0]  r4_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= w_s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_n1 <= (w_s1[SUM_W-1] ? '0 : (NW1'(w_s1) << FB)) +
                     NW1'(w_s[SDW:1]);
            r4_n2 <= (w_s2[SUM_W-1] ? '0 : (NW1'(w_s2) << FB)) +
                     NW1'(w_s[SDW:1]);
            r4_s    <= w_s[SDW-1:0];
            r4_spos <= w_s > 0;
            r4_pay  <= w_s_pay;
        end
    end

    logic           w_q1_vld, w_q2_vld, w_q1_sat, w_q2_sat;
    logic [QB-1:0]  w_q1, w_q2;
    logic [PA:0]    w_q1_pay;
    logic           w_q2_pay;

    qslerp_divider #(.NW(NW1), .DW(SDW), .QB(QB), .PW(PA+1)) u_div_w1 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(r4_vld), .i_n(r4_n1), .i_d(r4_s), .i_pay({r4_spos, r4_pay}),
        .o_vld(w_q1_vld), .o_q(w_q1), .o_sat(w_q1_sat), .o_pay(w_q1_pay)
    );
    qslerp_divider #(.NW(NW1), .DW(SDW), .QB(QB), .PW(1)) u_div_w2 (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(r4_vld), .i_n(r4_n2), .i_d(r4_s), .i_pay(1'b0),
        .o_vld(w_q2_vld), .o_q(w_q2), .o_sat(w_q2_sat), .o_pay(w_q2_pay)
    );

    // stage 5: weight select and weighted components
    logic                  w_spos, w_trig5, w_flip5;
    logic signed [WW-1:0]  w_w1, w_w2, w_c1, w_c2;
    logic                  r5_vld;
    logic signed [PWD-1:0] r5_p1 [0:3];
    logic signed [PWD-1:0] r5_p2 [0:3];

    always_comb begin
        w_spos  = w_q1_pay[PA];
        w_trig5 = w_q1_pay[0];
        w_flip5 = w_q1_pay[1];
        w_c1 = (w_q1_sat || w_q1 > QB'(ONE)) ? WW'(ONE) : WW'(w_q1);
        w_c2 = (w_q2_sat || w_q2 > QB'(ONE)) ? WW'(ONE) : WW'(w_q2);
        if (w_trig5 && w_spos) begin
            w_w1 = w_c1;
            w_w2 = w_c2;
        end else begin
            w_w1 = $signed(w_q1_pay[2+WW +: WW]);
            w_w2 = $signed(w_q1_pay[2 +: WW]);
        end
        if (w_flip5) begin
            w_w1 = -w_w1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= w_q1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r5_p2[i] <= PWD'(w_w2) * PWD'($signed(w_q1_pay[AB + i*CW +: CW]));
                r5_p1[i] <= PWD'(w_w1) * PWD'($signed(w_q1_pay[AB + (4+i)*CW +: CW]));
            end
        end
    end

    // stage 6: sum, sign and magnitude
    logic signed [PWD:0] w_q6 [0:3];
    logic                r6_vld;
    logic [MW-1:0]       r6_mag [0:3];
    logic [3:0]          r6_neg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_q6[i] = (PWD+1)'(r5_p1[i]) + (PWD+1)'(r5_p2[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (w_en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r6_neg[i] <= w_q6[i][PWD];
                r6_mag[i] <= w_q6[i][PWD] ? MW'(-w_q6[i]) : MW'(w_q6[i]);
            end
        end
    end

    // stage 7 and 8: squares, then their sum
    logic            r7_vld, r8_vld;
    logic [2*MW-1:0] r7_sq [0:3];
    logic [2*MW-1:0] r8_sum;
    logic [IPW-1:0]  r7_pay, r8_pay;
    logic [IPW-1:0]  w_pay6;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_pay6[i*MW +: MW] = r6_mag[i];
        end
        w_pay6[4*MW +: 4] = r6_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r7_sq[i] <= (2*MW)'(r6_mag[i]) * (2*MW)'(r6_mag[i]);
            end
            r7_pay <= w_pay6;
            r8_sum <= r7_sq[0] + r7_sq[1] + r7_sq[2] + r7_sq[3];
            r8_pay <= r7_pay;
        end
    end

    logic           w_m_vld;
    logic [MW-1:0]  w_m;
    logic [IPW-1:0] w_m_pay;

    qslerp_isqrt #(.HW(MW), .PW(IPW)) u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(r8_vld), .i_v(r8_sum), .i_pay(r8_pay),
        .o_vld(w_m_vld), .o_root(w_m), .o_pay(w_m_pay)
    );

    // normalizing dividers, one lane per component
    logic          w_r_vld [0:3];
    logic [QB-1:0] w_r_q   [0:3];
    logic          w_r_sat [0:3];
    logic [4:0]    w_r_pay [0:3];

    for (genvar i = 0; i < 4; i++) begin : g_norm
        qslerp_divider #(.NW(NW2), .DW(MW), .QB(QB), .PW(5)) u_div (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
            .i_vld(w_m_vld),
            .i_n((NW2'(w_m_pay[i*MW +: MW]) << FB) + NW2'(w_m >> 1)),
            .i_d(w_m),
            .i_pay({w_m_pay[4*MW +: 4], w_m == '0}),
            .o_vld(w_r_vld[i]), .o_q(w_r_q[i]), .o_sat(w_r_sat[i]),
            .o_pay(w_r_pay[i])
        );
    end

    // output register
    logic          r_out_vld, r_out_deg;
    logic [CW-1:0] r_out_r [0:3];
    logic [FB:0]   w_rc [0:3];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rc[i] = (w_r_sat[i] || w_r_q[i] > QB'(ONE)) ? ONE : w_r_q[i][FB:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_r_vld[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_deg <= w_r_pay[0][0];
            for (int i = 0; i < 4; i++) begin
                if (w_r_pay[0][0]) begin
                    r_out_r[i] <= '0;
                end else if (w_r_pay[0][1+i]) begin
                    r_out_r[i] <= -CW'(w_rc[i]);
                end else begin
                    r_out_r[i] <= CW'(w_rc[i]);
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_deg;
    assign m_axis_tdata  = OW'({r_out_r[3], r_out_r[2], r_out_r[1], r_out_r[0]});
endmodule

// File: verif/tb_top.sv
// self-checking testbench for the quaternion slerp pipeline
module tb_top;
    import qslerp_pkg::*;

    localparam int FB       = 14;
    localparam int CW       = 16;
    localparam int PIPE_LAT = 700;
    localparam int MAX_CYC  = 800000;
    localparam longint ONE_Q = 64'sd1 << FB;
    localparam longint ANG1  = 64'sd1 << ANG_BITS;

    typedef struct {
        logic signed [CW-1:0] a [4];
        logic signed [CW-1:0] b [4];
        logic signed [CW-1:0] blend;
    } slerp_req_t;

    typedef struct {
        logic signed [CW-1:0] r [4];
        logic                 degenerate;
    } rotation_t;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [NEAR_W-1:0]  i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [143:0]       s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [63:0]        m_axis_tdata;
    logic               m_axis_tuser;

    rotation_t          pending_rotations[$];
    logic [NEAR_W-1:0]  near_thr;
    int                 mismatches;
    int                 cycles;
    int                 out_hold;
    bit                 out_free;

    quaternion_slerp #(.FRAC_BITS(FB), .COMPONENT_WIDTH(CW)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // sin when odd is set, else cos, Q.30 taylor series
    function automatic longint trig_q30(longint x, bit odd);
        longint term, sum, k;
        term = odd ? x : ANG1;
        sum  = term;
        k    = odd ? 1 : 0;
        for (int i = 1; i < SERIES_TERMS; i++) begin
            term = (term * x) >>> ANG_BITS;
            term = (term * x) >>> ANG_BITS;
            term = term / ((k + 1) * (k + 2));
            k += 2;
            sum = (i & 1) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic longint acos_q30(longint d30);
        longint th, cand;
        th = 0;
        for (int bi = ANG_BITS; bi >= 0; bi--) begin
            cand = th | (64'sd1 << bi);
            if (cand <= longint'(HALF_PI_Q) && trig_q30(cand, 1'b0) >= d30) th = cand;
        end
        return th;
    endfunction

    function automatic longint arc_weight(longint num, longint s);
        longint w;
        if (num < 0) num = 0;
        w = ((num <<< FB) + s / 2) / s;
        return (w > ONE_Q) ? ONE_Q : w;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bt;
        res = 0;
        bt  = 64'd1 << 62;
        while (bt > v) bt >>= 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v  -= res + bt;
                res = (res >> 1) + bt;
            end else begin
                res >>= 1;
            end
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic rotation_t slerp_predict(slerp_req_t rq, logic [NEAR_W-1:0] thr);
        rotation_t       rot;
        longint          t, w1, w2, d, th, s;
        longint          q [4];
        longint unsigned mg [4];
        longint unsigned sum, m, r;
        bit              flip;
        t = rq.blend;
        if (t < 0) begin
            w2 = ONE_Q; w1 = 0;
        end else if (t > ONE_Q) begin
            w2 = 0; w1 = ONE_Q;
        end else begin
            d = 0;
            for (int i = 0; i < 4; i++) d += (longint'(rq.a[i]) * longint'(rq.b[i])) >>> FB;
            flip = d < 0;
            if (flip) d = -d;
            w2 = ONE_Q - t;
            w1 = t;
            if (d <= longint'(thr)) begin
                if (d > ONE_Q) d = ONE_Q;
                th = acos_q30(d <<< (ANG_BITS - FB));
                s  = trig_q30(th, 1'b1);
                if (s > 0) begin
                    w1 = arc_weight(trig_q30((t * th) >>> FB, 1'b1), s);
                    w2 = arc_weight(trig_q30(((ONE_Q - t) * th) >>> FB, 1'b1), s);
                end
            end
            if (flip) w1 = -w1;
        end
        sum = 0;
        for (int i = 0; i < 4; i++) begin
            q[i]  = w2 * rq.a[i] + w1 * rq.b[i];
            mg[i] = (q[i] < 0) ? longint'(-q[i]) : q[i];
            sum  += mg[i] * mg[i];
        end
        m = int_sqrt(sum);
        rot.degenerate = (m == 0);
        for (int i = 0; i < 4; i++) begin
            if (m == 0) begin
                rot.r[i] = '0;
            end else begin
                r = ((mg[i] << FB) + m / 2) / m;
                if (r > ONE_Q) r = ONE_Q;
                if (q[i] < 0) r = -r;
                rot.r[i] = r[CW-1:0];
            end
        end
        return rot;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10) return 0;
        if (sel < 18) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(slerp_req_t rq);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rq.blend, rq.b[3], rq.b[2], rq.b[1], rq.b[0],
                          rq.a[3], rq.a[2], rq.a[1], rq.a[0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_rotations.push_back(slerp_predict(rq, near_thr));
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pipe();
        s_axis_tvalid <= 1'b0;
        while (pending_rotations.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [NEAR_W-1:0] val);
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        near_thr = val;
    endtask

    function automatic slerp_req_t mk_req(int ax, int ay, int az, int aw,
                                          int bx, int by, int bz, int bw, int t);
        slerp_req_t rq;
        rq.a[0] = ax; rq.a[1] = ay; rq.a[2] = az; rq.a[3] = aw;
        rq.b[0] = bx; rq.b[1] = by; rq.b[2] = bz; rq.b[3] = bw;
        rq.blend = t;
        return rq;
    endfunction

    function automatic slerp_req_t rand_req();
        slerp_req_t rq;
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++) begin
            if (kind < 7) rq.a[i] = $urandom_range(0, 32768) - 16384;
            else          rq.a[i] = $urandom;
        end
        for (int i = 0; i < 4; i++) begin
            if (kind < 3)      rq.b[i] = rq.a[i] + $urandom_range(0, 800) - 400;
            else if (kind < 4) rq.b[i] = -rq.a[i] + $urandom_range(0, 800) - 400;
            else if (kind < 7) rq.b[i] = $urandom_range(0, 32768) - 16384;
            else               rq.b[i] = $urandom;
        end
        if (kind < 8) rq.blend = $urandom_range(0, 16384);
        else          rq.blend = $urandom;
        return rq;
    endfunction

    task automatic test_directed();
        send_request(mk_req(0, 0, 0, 0, 0, 0, 0, 0, 8192));
        send_request(mk_req(0, 0, 0, 0, 0, 0, 0, 0, -1));
        send_request(mk_req(16384, 0, 0, 0, 0, 16384, 0, 0, -32768));
        send_request(mk_req(16384, 0, 0, 0, 0, 16384, 0, 0, 32767));
        send_request(mk_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16385));
        send_request(mk_req(16384, 0, 0, 0, 0, 16384, 0, 0, 0));
        send_request(mk_req(16384, 0, 0, 0, 0, 16384, 0, 0, 16384));
        send_request(mk_req(16384, 0, 0, 0, 0, 16384, 0, 0, 8192));
        send_request(mk_req(0, 0, 0, 16384, 0, 0, 0, 16384, 5000));
        send_request(mk_req(0, 0, 0, 16384, 0, 0, 0, -16384, 5000));
        send_request(mk_req(0, 0, 0, 16384, 0, 0, 0, -16384, 8192));
        send_request(mk_req(11585, 0, 0, 11585, -11585, 0, 0, 11585, 3000));
        send_request(mk_req(0, 0, 16384, 0, 100, 0, -16384, 0, 12000));
        send_request(mk_req(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 4000));
        send_request(mk_req(-32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, -32768, 9000));
        send_request(mk_req(32767, -32768, 32767, -32768, -32768, 32767, -32768, 32767, 7000));
        send_request(mk_req(16384, 0, 0, 0, 16380, 300, 0, 0, 6000));
        send_request(mk_req(1, 0, 0, 0, 0, 1, 0, 0, 8192));
        send_request(mk_req(16384, 0, 0, 0, -16384, 0, 0, 0, 8192));
        send_request(mk_req(0, 0, 0, 0, 16384, 16384, 0, 0, 16384));
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) send_request(rand_req());
    endtask

    task automatic test_threshold_sweep();
        write_threshold(15'd0);
        test_directed();
        test_random(60);
        write_threshold(15'd16384);
        test_random(60);
        write_threshold(15'h7FFF);
        test_random(30);
        write_threshold(15'd8000);
        test_random(60);
        write_threshold($urandom_range(0, 16384));
        test_random(60);
        write_threshold(15'd16383);
        test_random(80);
    endtask

    // result check and output backpressure
    always @(posedge i_clk) begin
        rotation_t want;
        bit        bad;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_rotations.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h deg=%b",
                                               m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_rotations.pop_front();
                bad  = (m_axis_tuser !== want.degenerate);
                for (int i = 0; i < 4; i++)
                    if (m_axis_tdata[16*i +: 16] !== want.r[i]) bad = 1;
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h %h deg=%b got %h deg=%b",
                                 want.r[0], want.r[1], want.r[2], want.r[3],
                                 want.degenerate, m_axis_tdata, m_axis_tuser);
                end
            end
        end
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
        end else begin
            out_free      <= ($urandom_range(0, 3) == 0);
            out_hold      <= $urandom_range(20, 200);
        end
        m_axis_tready <= out_free ? 1'b1 : (pick_gap() == 0);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= MAX_CYC) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        m_axis_tready <= 1'b0;
        mismatches    = 0;
        cycles        = 0;
        out_hold      = 0;
        out_free      = 1'b1;
        near_thr      = NEAR_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(100);
        test_threshold_sweep();
        drain_pipe();
        if (mismatches == 0 && pending_rotations.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/qslerp_pkg.sv
rtl/qslerp_term_cell.sv
rtl/qslerp_series.sv
rtl/qslerp_acos_cell.sv
rtl/qslerp_divider.sv
rtl/qslerp_isqrt.sv
rtl/quaternion_slerp.sv
verif/tb_top.sv
